FILE: hdl/sip24_pkg.sv
// shared types, constants and control codes of the siphash-2-4 engine
package sip24_pkg;

   localparam int WORD_W    = 64;
   localparam int COUNT_W   = 4;
   localparam int LEN_W     = 8;
   localparam int BYTES     = WORD_W / 8;
   localparam int CSR_IDX_W = 2;
   localparam int FIN_ROUNDS = 4;
   localparam int FIN_CNT_W = $clog2(FIN_ROUNDS);

   localparam logic [WORD_W-1:0] INIT_A = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] INIT_B = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] INIT_C = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] INIT_D = 64'h7465646279746573;
   localparam logic [WORD_W-1:0] KEY_LOW_RESET  = 64'h0706050403020100;
   localparam logic [WORD_W-1:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
   localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTES);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd1;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
   } lanes_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMP2,
      ST_PAD1,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic ready;
      logic rnd_en;
      logic d_xor;
      logic a_xor;
      logic c_xor;
      logic pad_sel;
      logic done;
   } ctl_type;

endpackage

FILE: hdl/sip24_req_if.sv
// input channel: one message word per item
interface sip24_req_if;
   logic                            valid;
   logic                            ready;
   logic [sip24_pkg::WORD_W-1:0]    message_word;
   logic [sip24_pkg::COUNT_W-1:0]   byte_count;
   logic                            last_word;

   modport source (output valid, output message_word, output byte_count, output last_word,
                   input ready);
   modport sink   (input valid, input message_word, input byte_count, input last_word,
                   output ready);
endinterface

FILE: hdl/sip24_rsp_if.sv
// result channel: one hash per message
interface sip24_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sip24_pkg::WORD_W-1:0]    hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

FILE: hdl/sip24_round.sv
// one sipround over the four lanes
module sip24_round (
   input  sip24_pkg::lanes_type lanes_i,
   output sip24_pkg::lanes_type lanes_o
);

   logic [sip24_pkg::WORD_W-1:0] c1, d1, a1, b1, a2, c2, a3, b2, d2, c3;

   always_comb begin
      c1 = lanes_i.c + lanes_i.d;
      d1 = {lanes_i.d[47:0], lanes_i.d[63:48]} ^ c1;
      a1 = lanes_i.a + lanes_i.b;
      b1 = {lanes_i.b[50:0], lanes_i.b[63:51]} ^ a1;
      a2 = {a1[31:0], a1[63:32]};
      c2 = c1 + b1;
      a3 = a2 + d1;
      b2 = {b1[46:0], b1[63:47]} ^ c2;
      d2 = {d1[42:0], d1[63:43]} ^ a3;
      c3 = {c2[31:0], c2[63:32]};
      lanes_o.a = a3;
      lanes_o.b = b2;
      lanes_o.c = c3;
      lanes_o.d = d2;
   end

endmodule

FILE: hdl/sip24_ctrl.sv
// sequencer: compression, padding block and finalization rounds
module sip24_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   input  logic                req_full,
   input  logic                out_free,
   output sip24_pkg::ctl_type  ctl
);

   sip24_pkg::state_type            state_ff, state_in;
   logic [sip24_pkg::FIN_CNT_W-1:0] fin_cnt_ff, fin_cnt_in;
   logic                            pad_pending_ff, pad_pending_in;
   logic                            final_ff, final_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sip24_pkg::ST_IDLE;
         fin_cnt_ff     <= '0;
         pad_pending_ff <= 1'b0;
         final_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         fin_cnt_ff     <= fin_cnt_in;
         pad_pending_ff <= pad_pending_in;
         final_ff       <= final_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      fin_cnt_in     = fin_cnt_ff;
      pad_pending_in = pad_pending_ff;
      final_in       = final_ff;
      ctl            = '0;
      unique case (state_ff)
         sip24_pkg::ST_IDLE: begin
            ctl.ready = 1'b1;
            if (req_valid) begin
               // first round of the word, message folded into lane d
               ctl.rnd_en     = 1'b1;
               ctl.d_xor      = 1'b1;
               pad_pending_in = req_last & req_full;
               final_in       = req_last;
               state_in       = sip24_pkg::ST_COMP2;
            end
         end
         sip24_pkg::ST_COMP2: begin
            ctl.rnd_en = 1'b1;
            ctl.a_xor  = 1'b1;
            if (pad_pending_ff) begin
               state_in = sip24_pkg::ST_PAD1;
            end else if (final_ff) begin
               fin_cnt_in = '0;
               state_in   = sip24_pkg::ST_FIN;
            end else begin
               state_in = sip24_pkg::ST_IDLE;
            end
         end
         sip24_pkg::ST_PAD1: begin
            ctl.rnd_en     = 1'b1;
            ctl.d_xor      = 1'b1;
            ctl.pad_sel    = 1'b1;
            pad_pending_in = 1'b0;
            state_in       = sip24_pkg::ST_COMP2;
         end
         sip24_pkg::ST_FIN: begin
            ctl.c_xor = (fin_cnt_ff == '0);
            if (fin_cnt_ff == sip24_pkg::FIN_CNT_W'(sip24_pkg::FIN_ROUNDS - 1)) begin
               // last round waits until the result register is free
               if (out_free) begin
                  ctl.rnd_en = 1'b1;
                  ctl.done   = 1'b1;
                  final_in   = 1'b0;
                  state_in   = sip24_pkg::ST_IDLE;
               end
            end else begin
               ctl.rnd_en = 1'b1;
               fin_cnt_in = fin_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = sip24_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/siphash_2_4_engine.sv
// siphash-2-4 engine top level: lane registers, key registers, result register
// non-last word: compression rounds through one round unit, one sipround per cycle
// last word: compression, a padding block when it holds all 8 bytes, then finalization;
// the last finalization round waits for the previous result to be taken, holding the rounds
// a new word is taken only once the last one is through, ready is low while busy
// reset: keys return to their default value, lanes reload from them, length clears
module siphash_2_4_engine (
   input  logic                              clock,
   input  logic                              reset,
   sip24_req_if.sink                         req_chan,
   sip24_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [sip24_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sip24_pkg::WORD_W-1:0]      csr_wdata
);

   sip24_pkg::ctl_type   ctl;
   sip24_pkg::lanes_type lanes_ff, lanes_in, round_in, round_out, reload;

   logic [sip24_pkg::WORD_W-1:0]  key_low_ff, key_low_in;
   logic [sip24_pkg::WORD_W-1:0]  key_high_ff, key_high_in;
   logic [sip24_pkg::WORD_W-1:0]  msg_ff, msg_in;
   logic [sip24_pkg::WORD_W-1:0]  hash_ff, hash_in;
   logic                          out_full_ff, out_full_in;
   logic [sip24_pkg::LEN_W-1:0]   len_ff, len_in, len_new;

   logic [sip24_pkg::COUNT_W-1:0] count_sat;
   logic [sip24_pkg::WORD_W-1:0]  masked_word, block, pad_block, fold_msg;
   logic                          accept, key_write, out_free;

   // sequencer
   sip24_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_word),
      .req_full  (count_sat == sip24_pkg::FULL_COUNT),
      .out_free  (out_free),
      .ctl       (ctl)
   );

   // shared round unit
   sip24_round u_round (
      .lanes_i (round_in),
      .lanes_o (round_out)
   );

   assign accept         = req_chan.valid & ctl.ready;
   assign req_chan.ready = ctl.ready;
   assign rsp_chan.valid = out_full_ff;
   assign rsp_chan.hash_value = hash_ff;
   assign out_free       = ~out_full_ff | rsp_chan.ready;

   assign key_write = csr_we & ((csr_index == sip24_pkg::CSR_KEY_LOW) |
                                (csr_index == sip24_pkg::CSR_KEY_HIGH));

   // message block of the incoming item
   always_comb begin
      // counts above eight saturate
      count_sat = (req_chan.byte_count > sip24_pkg::FULL_COUNT) ?
                  sip24_pkg::FULL_COUNT : req_chan.byte_count;
      // bytes at or above the count read as zero
      for (int i = 0; i < sip24_pkg::BYTES; i++) begin
         masked_word[8*i +: 8] = (sip24_pkg::COUNT_W'(i) < count_sat) ?
                                 req_chan.message_word[8*i +: 8] : 8'h00;
      end
      len_new = req_chan.last_word ? (len_ff + sip24_pkg::LEN_W'(count_sat)) :
                (len_ff + sip24_pkg::LEN_W'(sip24_pkg::BYTES));
      if (!req_chan.last_word) begin
         block = req_chan.message_word;
      end else if (count_sat == sip24_pkg::FULL_COUNT) begin
         // full last word, length goes into a separate padding block
         block = req_chan.message_word;
      end else begin
         block = masked_word | {len_new, {(sip24_pkg::WORD_W-sip24_pkg::LEN_W){1'b0}}};
      end
      pad_block = {len_ff, {(sip24_pkg::WORD_W-sip24_pkg::LEN_W){1'b0}}};
      fold_msg  = ctl.pad_sel ? pad_block : block;
   end

   // round unit operands
   always_comb begin
      round_in   = lanes_ff;
      round_in.c = lanes_ff.c ^ (ctl.c_xor ? sip24_pkg::FINAL_XOR : '0);
      round_in.d = lanes_ff.d ^ (ctl.d_xor ? fold_msg : '0);
   end

   // next state of keys, lanes, length and result
   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_we && csr_index == sip24_pkg::CSR_KEY_LOW) begin
         key_low_in = csr_wdata;
      end
      if (csr_we && csr_index == sip24_pkg::CSR_KEY_HIGH) begin
         key_high_in = csr_wdata;
      end

      reload.a = key_low_in  ^ sip24_pkg::INIT_A;
      reload.b = key_high_in ^ sip24_pkg::INIT_B;
      reload.c = key_low_in  ^ sip24_pkg::INIT_C;
      reload.d = key_high_in ^ sip24_pkg::INIT_D;

      lanes_in = lanes_ff;
      if (key_write || ctl.done) begin
         lanes_in = reload;
      end else if (ctl.rnd_en) begin
         lanes_in   = round_out;
         lanes_in.a = round_out.a ^ (ctl.a_xor ? msg_ff : '0);
      end

      msg_in = ctl.d_xor ? fold_msg : msg_ff;

      len_in = len_ff;
      if (key_write || ctl.done) begin
         len_in = '0;
      end else if (accept) begin
         len_in = len_new;
      end

      hash_in     = hash_ff;
      out_full_in = out_full_ff;
      if (ctl.done) begin
         hash_in     = round_out.a ^ round_out.b ^ round_out.c ^ round_out.d;
         out_full_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= sip24_pkg::KEY_LOW_RESET;
         key_high_ff <= sip24_pkg::KEY_HIGH_RESET;
         lanes_ff.a  <= sip24_pkg::KEY_LOW_RESET  ^ sip24_pkg::INIT_A;
         lanes_ff.b  <= sip24_pkg::KEY_HIGH_RESET ^ sip24_pkg::INIT_B;
         lanes_ff.c  <= sip24_pkg::KEY_LOW_RESET  ^ sip24_pkg::INIT_C;
         lanes_ff.d  <= sip24_pkg::KEY_HIGH_RESET ^ sip24_pkg::INIT_D;
         len_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         key_low_ff  <= key_low_in;
         key_high_ff <= key_high_in;
         lanes_ff    <= lanes_in;
         len_ff      <= len_in;
         out_full_ff <= out_full_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      msg_ff  <= msg_in;
      hash_ff <= hash_in;
   end

endmodule

FILE: hdl/sip24_checker.sv
// port-level checks of the siphash-2-4 engine, bound to the top level
module sip24_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_last,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sip24_pkg::WORD_W-1:0] rsp_hash
);

   // after reset the engine is empty and takes items
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("engine not idle after reset");

   // busy right after taking an item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready high in the cycle after an item");

   // after a non-last word the engine is ready again once its compression rounds are done
   a_word_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last) |=> ##1 req_ready)
      else $error("non-last word not finished in two cycles");

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_hash)))
      else $error("result dropped or changed while stalled");

endmodule

bind siphash_2_4_engine sip24_checker u_sip24_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_word),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_hash  (rsp_chan.hash_value)
);

FILE: test/siphash_2_4_engine_tb.sv
// testbench for the siphash-2-4 engine: directed and random messages checked against a lane model
`timescale 1ns / 100ps

module siphash_2_4_engine_tb;

   // register indexes that decode to nothing
   localparam logic [sip24_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sip24_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int IDLE_PCT     = 19;   // chance of an idle cycle on either side
   localparam int DRAIN_CYCLES = 16;   // longest last-word latency with margin
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 130;  // five key phases, about 650 items in all

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic [sip24_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [sip24_pkg::WORD_W-1:0]        csr_wdata;

   sip24_req_if req_chan();
   sip24_rsp_if rsp_chan();

   siphash_2_4_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // lane model: keys, the four lanes and the running length
   logic [sip24_pkg::WORD_W-1:0] key_lo_model;
   logic [sip24_pkg::WORD_W-1:0] key_hi_model;
   sip24_pkg::lanes_type         lanes_model;
   logic [sip24_pkg::LEN_W-1:0]  length_model;

   // hashes still owed by the engine, oldest first
   logic [sip24_pkg::WORD_W-1:0] pending_hashes[$];

   int err_count;
   int items_sent;
   bit steady;   // set for the stretch with no idling on either side

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [sip24_pkg::WORD_W-1:0] rotl64(
         logic [sip24_pkg::WORD_W-1:0] x, int unsigned n);
      return (x << n) | (x >> (sip24_pkg::WORD_W - n));
   endfunction

   function automatic sip24_pkg::lanes_type sip_round(sip24_pkg::lanes_type s);
      s.c = s.c + s.d;
      s.d = rotl64(s.d, 16) ^ s.c;
      s.a = s.a + s.b;
      s.b = rotl64(s.b, 13) ^ s.a;
      s.a = rotl64(s.a, 32);
      s.c = s.c + s.b;
      s.a = s.a + s.d;
      s.b = rotl64(s.b, 17) ^ s.c;
      s.d = rotl64(s.d, 21) ^ s.a;
      s.c = rotl64(s.c, 32);
      return s;
   endfunction

   // fresh message: lanes from the keys, length cleared
   function automatic void reload_lanes();
      lanes_model.a = key_lo_model ^ sip24_pkg::INIT_A;
      lanes_model.b = key_hi_model ^ sip24_pkg::INIT_B;
      lanes_model.c = key_lo_model ^ sip24_pkg::INIT_C;
      lanes_model.d = key_hi_model ^ sip24_pkg::INIT_D;
      length_model  = '0;
   endfunction

   // one block through two compression rounds
   function automatic void absorb_block(logic [sip24_pkg::WORD_W-1:0] m);
      lanes_model.d ^= m;
      lanes_model = sip_round(sip_round(lanes_model));
      lanes_model.a ^= m;
   endfunction

   // one message word into the model; returns 1 with the hash on the last word
   function automatic bit absorb_word(input logic [sip24_pkg::WORD_W-1:0] word,
                                      input logic [sip24_pkg::COUNT_W-1:0] count,
                                      input logic last,
                                      output logic [sip24_pkg::WORD_W-1:0] hash);
      logic [sip24_pkg::COUNT_W-1:0] n;
      logic [sip24_pkg::WORD_W-1:0]  block;
      hash = '0;
      // non-last words are always full, the count is ignored
      if (!last) begin
         absorb_word_full: begin
            absorb_block(word);
            length_model += sip24_pkg::LEN_W'(sip24_pkg::BYTES);
         end
         return 1'b0;
      end
      // counts above eight saturate
      n = (count > sip24_pkg::FULL_COUNT) ? sip24_pkg::FULL_COUNT : count;
      length_model += sip24_pkg::LEN_W'(n);
      block = '0;
      // a full last word goes in whole, then a block with only the length
      if (n == sip24_pkg::FULL_COUNT)
         absorb_block(word);
      else if (n != '0)
         block = word & ((64'd1 << (8 * n)) - 64'd1);
      block |= {length_model, 56'd0};
      absorb_block(block);
      // finalization
      lanes_model.c ^= sip24_pkg::FINAL_XOR;
      repeat (sip24_pkg::FIN_ROUNDS) lanes_model = sip_round(lanes_model);
      hash = lanes_model.a ^ lanes_model.b ^ lanes_model.c ^ lanes_model.d;
      reload_lanes();
      return 1'b1;
   endfunction

   function automatic logic [sip24_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic flag_error(input string what, input logic [sip24_pkg::WORD_W-1:0] want,
                             input logic [sip24_pkg::WORD_W-1:0] got);
      if (err_count < MAX_REPORTS)
         $display("%0t: %s: expected %h, got %h", $time, what, want, got);
      err_count++;
   endtask

   // result side: ready drops at random unless in the steady stretch
   always @(negedge clock) rsp_chan.ready = steady || ($urandom_range(99) >= IDLE_PCT);

   // every accepted hash against the oldest one owed
   always @(posedge clock) begin : check_hashes
      logic [sip24_pkg::WORD_W-1:0] want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_hashes.size() == 0) begin
            flag_error("hash with none pending", 'x, rsp_chan.hash_value);
         end else begin
            want = pending_hashes.pop_front();
            if (rsp_chan.hash_value !== want)
               flag_error("hash_value", want, rsp_chan.hash_value);
         end
      end
   end

   // drive one item, with random idle cycles ahead of it, and wait for the handshake;
   // valid stays high afterwards so back-to-back items have no gap
   task automatic send_word(input logic [sip24_pkg::WORD_W-1:0] word,
                            input logic [sip24_pkg::COUNT_W-1:0] count,
                            input logic last);
      logic [sip24_pkg::WORD_W-1:0] hash;
      @(negedge clock);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.message_word = word;
      req_chan.byte_count   = count;
      req_chan.last_word    = last;
      do @(posedge clock); while (!req_chan.ready);
      if (absorb_word(word, count, last, hash))
         pending_hashes.push_back(hash);
      items_sent++;
   endtask

   // stop sending, wait for every owed hash and for the engine to go quiet
   task automatic settle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; a key write restarts the message in the model too
   task automatic write_csr(input logic [sip24_pkg::CSR_IDX_W-1:0] index,
                            input logic [sip24_pkg::WORD_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      if (index == sip24_pkg::CSR_KEY_LOW) begin
         key_lo_model = data;
         reload_lanes();
      end else if (index == sip24_pkg::CSR_KEY_HIGH) begin
         key_hi_model = data;
         reload_lanes();
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // mostly short messages, now and then one long enough to wrap the length byte
   task automatic send_random_message();
      int                            words;
      logic [sip24_pkg::COUNT_W-1:0] count;
      words = ($urandom_range(15) == 0) ? $urandom_range(40, 30) : $urandom_range(5);
      repeat (words)
         send_word(random_word(),
                   ($urandom_range(7) == 0) ? sip24_pkg::COUNT_W'($urandom_range(15))
                                            : sip24_pkg::FULL_COUNT, 1'b0);
      count = ($urandom_range(9) == 0) ? sip24_pkg::COUNT_W'($urandom_range(15, 9))
                                       : sip24_pkg::COUNT_W'($urandom_range(8));
      send_word(random_word(), count, 1'b1);
   endtask

   // single-word messages over the count range: empty, partial, full, saturated,
   // mostly with all-ones words so stray bytes above the count would show
   task automatic test_last_word_counts();
      send_word('0, 4'd0, 1'b1);
      send_word('1, 4'd0, 1'b1);
      send_word('1, 4'd1, 1'b1);
      send_word('1, 4'd3, 1'b1);
      send_word(random_word(), 4'd5, 1'b1);
      send_word('1, 4'd7, 1'b1);
      send_word('1, sip24_pkg::FULL_COUNT, 1'b1);
      send_word('1, 4'd9, 1'b1);
      send_word('1, 4'd15, 1'b1);
      send_word('0, 4'd15, 1'b1);
   endtask

   // counts on non-last words mean nothing; full last word needs the padding block
   task automatic test_ignored_count();
      send_word('0, 4'd0, 1'b0);
      send_word('1, 4'd15, 1'b0);
      send_word(random_word(), sip24_pkg::FULL_COUNT, 1'b1);
   endtask

   // key write drops a half-done message; writes to unused indexes change nothing
   task automatic test_key_reload();
      send_word(random_word(), sip24_pkg::FULL_COUNT, 1'b0);
      send_word(random_word(), sip24_pkg::FULL_COUNT, 1'b0);
      settle();
      write_csr(sip24_pkg::CSR_KEY_LOW, {$urandom, $urandom});
      send_word(random_word(), 4'd4, 1'b1);
      send_word(random_word(), sip24_pkg::FULL_COUNT, 1'b0);
      settle();
      write_csr(CSR_SPARE_2, '1);
      write_csr(CSR_SPARE_3, {$urandom, $urandom});
      send_word(random_word(), 4'd6, 1'b1);
   endtask

   // one key setting, then random messages until the item budget is used
   task automatic test_random_messages(input logic [sip24_pkg::WORD_W-1:0] k0,
                                       input logic [sip24_pkg::WORD_W-1:0] k1,
                                       input bit no_idle);
      int stop_at;
      settle();
      write_csr(sip24_pkg::CSR_KEY_LOW, k0);
      write_csr(sip24_pkg::CSR_KEY_HIGH, k1);
      steady  = no_idle;
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) send_random_message();
      steady = 1'b0;
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = sip24_pkg::CSR_KEY_LOW;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.message_word = '0;
      req_chan.byte_count   = '0;
      req_chan.last_word    = 1'b0;
      rsp_chan.ready        = 1'b0;
      err_count             = 0;
      items_sent            = 0;
      steady                = 1'b0;
      key_lo_model          = sip24_pkg::KEY_LOW_RESET;
      key_hi_model          = sip24_pkg::KEY_HIGH_RESET;
      reload_lanes();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default keys straight out of reset
      test_last_word_counts();
      test_ignored_count();
      test_key_reload();

      // default keys, key extremes, then random keys; the all-ones phase runs with no idling
      test_random_messages(sip24_pkg::KEY_LOW_RESET, sip24_pkg::KEY_HIGH_RESET, 1'b0);
      test_random_messages('0, '0, 1'b0);
      test_random_messages('1, '1, 1'b1);
      test_random_messages({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      test_random_messages({$urandom, $urandom}, '1, 1'b0);

      settle();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
hdl/sip24_pkg.sv
hdl/sip24_req_if.sv
hdl/sip24_rsp_if.sv
hdl/sip24_round.sv
hdl/sip24_ctrl.sv
hdl/siphash_2_4_engine.sv
hdl/sip24_checker.sv
test/siphash_2_4_engine_tb.sv
